// ===== rtl/clc_pkg.sv =====
package clc_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int DIST_W    = 16;
  localparam int ADDR_W    = 2 * IDX_W;

  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 5'd16;
  localparam logic [CNT_W-1:0] NODE_COUNT_MIN   = 5'd2;
  localparam logic [CNT_W-1:0] NODE_COUNT_MAX   = 5'd16;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_MIRROR   = 14'b00000000000010,
    S_SCAN_RD  = 14'b00000000000100,
    S_SCAN_CMP = 14'b00000000001000,
    S_LBL_A    = 14'b00000000010000,
    S_EMIT     = 14'b00000000100000,
    S_MRG_RDA  = 14'b00000001000000,
    S_MRG_RDB  = 14'b00000010000000,
    S_MRG_CALC = 14'b00000100000000,
    S_MRG_WR   = 14'b00001000000000,
    S_MOV_RD   = 14'b00010000000000,
    S_MOV_CAP  = 14'b00100000000000,
    S_SWAP     = 14'b01000000000000,
    S_MOV_WR   = 14'b10000000000000
  } state_t;

endpackage

// ===== rtl/clc_dist_ram.sv =====
module clc_dist_ram
  import clc_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  dist_t wdata,
  input  addr_t raddr,
  output dist_t rdata
);

  // One write port and one registered read port over the full square matrix.
  dist_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/complete_linkage_clustering_top.sv =====
// Complete-linkage clustering engine. Load the upper triangle of a symmetric
// distance matrix one entry per input beat (row_index, col_index, distance);
// each entry is written at both mirrored positions, the second write in its
// own state, so the input is stalled after each accepted beat while loading.
// The beat with last_entry set starts the clustering run of node_count-1
// merges, during which the input stays stalled. Each merge first scans all
// active pairs through the single read port of the distance memory, then
// rebuilds the merged row, writes it back, and moves the last active row
// into the freed slot. Every merge delivers one output beat with the merge
// distance and the two cluster labels, smaller first; if no nonzero
// distance remains, a single beat with no_pair set ends the run.
// last_merge marks the final beat of a run. node_count is saturated into
// 2..16 and must only be written while idle.
// The distance memory keeps its merged contents after a run, so every entry
// of the next matrix has to be loaded again.
module complete_linkage_clustering_top
  import clc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  row_index,
  input  logic [3:0]  col_index,
  input  logic [15:0] distance,
  input  logic        last_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] merge_distance,
  output logic [3:0]  left_label,
  output logic [3:0]  right_label,
  output logic        no_pair,
  output logic        last_merge
);

  state_t state;
  cnt_t   node_count;
  cnt_t   n;          // saturated node count of the current run
  cnt_t   h;          // merge step
  cnt_t   ci;
  cnt_t   cj;
  logic [1:0] wk;     // sub-step of the write-back sweep
  idx_t   ld_row;
  idx_t   ld_col;
  dist_t  ld_dist;
  logic   ld_last;
  logic   found;
  dist_t  best;
  idx_t   pa;
  idx_t   pb;
  dist_t  xval;
  idx_t   la_reg;
  idx_t   lb_reg;
  idx_t   labels [MAX_NODES];
  dist_t  mrow [MAX_NODES];

  logic   mem_we;
  addr_t  mem_waddr;
  dist_t  mem_wdata;
  addr_t  mem_raddr;
  dist_t  mem_rdata;

  cnt_t   act;
  cnt_t   lastc;
  idx_t   lastx;
  idx_t   lbl_idx;
  idx_t   lbl_rd;
  logic   in_acc;
  logic   out_free;
  cnt_t   n_sat;

  assign act      = n - h;
  assign lastc    = act - 5'd1;
  assign lastx    = lastc[IDX_W-1:0];
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (node_count < NODE_COUNT_MIN) begin
      n_sat = NODE_COUNT_MIN;
    end else if (node_count > NODE_COUNT_MAX) begin
      n_sat = NODE_COUNT_MAX;
    end else begin
      n_sat = node_count;
    end
  end

  // The label file is read at one place per cycle, chosen by the state.
  always_comb begin
    case (state)
      S_LBL_A: lbl_idx = pa;
      S_EMIT:  lbl_idx = pb;
      default: lbl_idx = lastx;
    endcase
  end
  assign lbl_rd = labels[lbl_idx];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {ld_row, ld_col};
    mem_wdata = mrow[ci[IDX_W-1:0]];
    mem_raddr = {ci[IDX_W-1:0], cj[IDX_W-1:0]};
    case (state)
      S_IDLE: begin
        mem_we    = in_acc;
        mem_waddr = {row_index, col_index};
        mem_wdata = distance;
      end
      S_MIRROR: begin
        mem_we    = 1'b1;
        mem_waddr = {ld_col, ld_row};
        mem_wdata = ld_dist;
      end
      S_MRG_RDA: mem_raddr = {pa, ci[IDX_W-1:0]};
      S_MRG_RDB: mem_raddr = {pb, ci[IDX_W-1:0]};
      S_MOV_RD:  mem_raddr = {lastx, ci[IDX_W-1:0]};
      S_MRG_WR: begin
        mem_we = 1'b1;
        case (wk)
          2'd0:    mem_waddr = {pa, ci[IDX_W-1:0]};
          2'd1:    mem_waddr = {ci[IDX_W-1:0], pa};
          2'd2:    mem_waddr = {pb, ci[IDX_W-1:0]};
          default: mem_waddr = {ci[IDX_W-1:0], pb};
        endcase
      end
      S_MOV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = wk[0] ? {ci[IDX_W-1:0], pb} : {pb, ci[IDX_W-1:0]};
      end
      default: ;
    endcase
  end

  clc_dist_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= NODE_COUNT_RESET;
      out_valid  <= 1'b0;
      h          <= '0;
      for (int k = 0; k < MAX_NODES; k++) begin
        labels[k] <= idx_t'(k);
      end
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            ld_row  <= row_index;
            ld_col  <= col_index;
            ld_dist <= distance;
            ld_last <= last_entry;
            state   <= S_MIRROR;
          end
        end
        S_MIRROR: begin
          if (ld_last) begin
            n     <= n_sat;
            h     <= '0;
            ci    <= '0;
            cj    <= 5'd1;
            found <= 1'b0;
            state <= S_SCAN_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (mem_rdata != '0 && (!found || mem_rdata < best)) begin
            found <= 1'b1;
            best  <= mem_rdata;
            pa    <= ci[IDX_W-1:0];
            pb    <= cj[IDX_W-1:0];
          end
          if (cj < lastc) begin
            cj    <= cj + 5'd1;
            state <= S_SCAN_RD;
          end else if (ci + 5'd2 <= lastc) begin
            ci    <= ci + 5'd1;
            cj    <= ci + 5'd2;
            state <= S_SCAN_RD;
          end else begin
            state <= S_LBL_A;
          end
        end
        S_LBL_A: begin
          la_reg <= lbl_rd;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (!found) begin
              merge_distance <= '0;
              left_label     <= '0;
              right_label    <= '0;
              no_pair        <= 1'b1;
              last_merge     <= 1'b1;
              h              <= '0;
              state          <= S_IDLE;
              for (int k = 0; k < MAX_NODES; k++) begin
                labels[k] <= idx_t'(k);
              end
            end else begin
              merge_distance <= best;
              left_label     <= (la_reg < lbl_rd) ? la_reg : lbl_rd;
              right_label    <= (la_reg < lbl_rd) ? lbl_rd : la_reg;
              no_pair        <= 1'b0;
              last_merge     <= (h + 5'd2 == n);
              lb_reg         <= lbl_rd;
              ci             <= '0;
              state          <= S_MRG_RDA;
            end
          end
        end
        S_MRG_RDA: state <= S_MRG_RDB;
        S_MRG_RDB: begin
          xval  <= mem_rdata;
          state <= S_MRG_CALC;
        end
        S_MRG_CALC: begin
          if (ci[IDX_W-1:0] == pa || ci[IDX_W-1:0] == pb) begin
            mrow[ci[IDX_W-1:0]] <= '0;
          end else begin
            mrow[ci[IDX_W-1:0]] <= (xval > mem_rdata) ? xval : mem_rdata;
          end
          if (ci + 5'd1 < n) begin
            ci    <= ci + 5'd1;
            state <= S_MRG_RDA;
          end else begin
            ci    <= '0;
            wk    <= '0;
            state <= S_MRG_WR;
          end
        end
        S_MRG_WR: begin
          wk <= wk + 2'd1;
          if (wk == 2'd3) begin
            if (ci + 5'd1 < n) begin
              ci <= ci + 5'd1;
            end else begin
              ci    <= '0;
              state <= S_MOV_RD;
            end
          end
        end
        S_MOV_RD: state <= S_MOV_CAP;
        S_MOV_CAP: begin
          mrow[ci[IDX_W-1:0]] <= (ci[IDX_W-1:0] == pb) ? '0 : mem_rdata;
          if (ci + 5'd1 < n) begin
            ci    <= ci + 5'd1;
            state <= S_MOV_RD;
          end else begin
            state <= S_SWAP;
          end
        end
        S_SWAP: begin
          // The last active slot takes the merged label and vice versa.
          labels[pb]    <= lbl_rd;
          labels[lastx] <= lb_reg;
          ci            <= '0;
          wk            <= '0;
          state         <= S_MOV_WR;
        end
        S_MOV_WR: begin
          wk <= {1'b0, ~wk[0]};
          if (wk[0]) begin
            if (ci + 5'd1 < lastc) begin
              ci <= ci + 5'd1;
            end else if (h + 5'd3 <= n) begin
              h     <= h + 5'd1;
              ci    <= '0;
              cj    <= 5'd1;
              found <= 1'b0;
              state <= S_SCAN_RD;
            end else begin
              h     <= '0;
              state <= S_IDLE;
              for (int k = 0; k < MAX_NODES; k++) begin
                labels[k] <= idx_t'(k);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/clc_checker.sv =====
`timescale 1ns / 100ps

module clc_checker
  import clc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  row_index,
  input  logic [3:0]  col_index,
  input  logic [15:0] distance,
  input  logic        last_entry,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] merge_distance,
  input  logic [3:0]  left_label,
  input  logic [3:0]  right_label,
  input  logic        no_pair,
  input  logic        last_merge,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    dist_t d;
    idx_t  lo;
    idx_t  hi;
    logic  none;
    logic  fin;
  } merge_t;

  merge_t merge_due[$];
  dist_t  dmat[MAX_NODES][MAX_NODES];
  idx_t   slot_lbl[MAX_NODES];
  cnt_t   nodes;

  // Runs a whole clustering pass over the stored matrix and queues one
  // expected beat per merge, or a no_pair beat once no nonzero pair is left.
  function automatic void merge_sweep();
    int    n, act, lst, a, b;
    logic  found;
    dist_t best, x, y;
    dist_t row[MAX_NODES];
    idx_t  la, lb, t;
    merge_t m;
    n = nodes;
    if (n < 2) n = 2;
    if (n > MAX_NODES) n = MAX_NODES;
    for (int h = 0; h + 2 <= n; h++) begin
      act = n - h;
      lst = act - 1;
      found = 1'b0;
      best = '0;
      a = 0;
      b = 0;
      for (int i = 0; i < act; i++) begin
        for (int j = i + 1; j < act; j++) begin
          if (dmat[i][j] != 0 && (!found || dmat[i][j] < best)) begin
            found = 1'b1;
            best = dmat[i][j];
            a = i;
            b = j;
          end
        end
      end
      if (!found) begin
        m = '{d: '0, lo: '0, hi: '0, none: 1'b1, fin: 1'b1};
        merge_due.insert(merge_due.size(), m);
        break;
      end
      la = slot_lbl[a];
      lb = slot_lbl[b];
      m = '{d: best, lo: (la < lb) ? la : lb, hi: (la < lb) ? lb : la,
            none: 1'b0, fin: (h + 2 == n)};
      merge_due.insert(merge_due.size(), m);
      for (int i = 0; i < n; i++) begin
        x = dmat[a][i];
        y = dmat[b][i];
        row[i] = (i == a || i == b) ? '0 : ((x > y) ? x : y);
      end
      for (int i = 0; i < n; i++) begin
        dmat[a][i] = row[i];
        dmat[i][a] = row[i];
        dmat[b][i] = row[i];
        dmat[i][b] = row[i];
      end
      for (int i = 0; i < n; i++) row[i] = (i != b) ? dmat[lst][i] : '0;
      t = slot_lbl[b];
      slot_lbl[b] = slot_lbl[lst];
      slot_lbl[lst] = t;
      for (int i = 0; i < lst; i++) begin
        dmat[b][i] = row[i];
        dmat[i][b] = row[i];
      end
    end
    for (int i = 0; i < MAX_NODES; i++) slot_lbl[i] = idx_t'(i);
  endfunction

  always @(posedge clk) begin
    merge_t e;
    if (rst) begin
      nodes = NODE_COUNT_RESET;
      for (int i = 0; i < MAX_NODES; i++) slot_lbl[i] = idx_t'(i);
      merge_due.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (merge_due.size() == 0) begin
          $error("unexpected result beat: distance %0d labels %0d/%0d",
                 merge_distance, left_label, right_label);
          errors++;
        end else begin
          e = merge_due.pop_front();
          if (merge_distance !== e.d) begin
            $error("merge_distance: expected %0d, got %0d", e.d, merge_distance);
            errors++;
          end
          if (left_label !== e.lo) begin
            $error("left_label: expected %0d, got %0d", e.lo, left_label);
            errors++;
          end
          if (right_label !== e.hi) begin
            $error("right_label: expected %0d, got %0d", e.hi, right_label);
            errors++;
          end
          if (no_pair !== e.none) begin
            $error("no_pair: expected %0d, got %0d", e.none, no_pair);
            errors++;
          end
          if (last_merge !== e.fin) begin
            $error("last_merge: expected %0d, got %0d", e.fin, last_merge);
            errors++;
          end
        end
      end
      if (cfg_wr_en) nodes = cfg_wr_data;
      if (in_valid && !in_stall) begin
        dmat[row_index][col_index] = distance;
        dmat[col_index][row_index] = distance;
        if (last_entry) merge_sweep();
      end
    end
    pending = merge_due.size();
  end

endmodule

// ===== dv/complete_linkage_clustering_top_tb.sv =====
`timescale 1ns / 100ps

module complete_linkage_clustering_top_tb;
  import clc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  row_index = '0;
  logic [3:0]  col_index = '0;
  logic [15:0] distance = '0;
  logic        last_entry = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] merge_distance;
  logic [3:0]  left_label;
  logic [3:0]  right_label;
  logic        no_pair;
  logic        last_merge;
  int          errors;
  int          pending;

  // Stimulus bookkeeping shared with the receiver process.
  int   beats_sent = 0;
  logic calm = 1'b0;      // set near the end: no more idling on either side
  logic steady = 1'b0;    // per-run stretches where nobody idles
  logic squeeze = 1'b0;   // asks the receiver for its one long hold-off
  logic squeezed = 1'b0;
  int   hold_left = 0;
  int   gap_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  complete_linkage_clustering_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .row_index(row_index), .col_index(col_index),
    .distance(distance), .last_entry(last_entry),
    .out_valid(out_valid), .out_stall(out_stall),
    .merge_distance(merge_distance), .left_label(left_label),
    .right_label(right_label), .no_pair(no_pair), .last_merge(last_merge)
  );

  clc_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .row_index(row_index), .col_index(col_index),
    .distance(distance), .last_entry(last_entry),
    .out_valid(out_valid), .out_stall(out_stall),
    .merge_distance(merge_distance), .left_label(left_label),
    .right_label(right_label), .no_pair(no_pair), .last_merge(last_merge),
    .errors(errors), .pending(pending)
  );

  // Receiver side. Random stall bursts, none once the run is calm or steady.
  // The single long hold-off is counted here so the sender keeps
  // offering beats while results back up inside the block.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (squeeze && !squeezed) begin
      squeezed <= 1'b1;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (calm || steady) begin
      out_stall <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      gap_left <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one entry beat and returns in the step where it is accepted.
  // The valid line is lowered for a sender gap and after the final beat, and
  // is never raised again in the same step.
  task automatic offer_entry(input int r, input int c, input int d, input bit fin);
    int g;
    g = 0;
    if (!calm && !steady && $urandom_range(0, 4) == 0) g = $urandom_range(1, 14);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    row_index <= r[3:0];
    col_index <= c[3:0];
    distance <= d[15:0];
    last_entry <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (fin) in_valid <= 1'b0;
  endtask

  // Writes node_count only when the block has gone quiet: all expected
  // beats delivered, then enough cycles for the tail of the last merge.
  // The first edge lets the checker queue the beats of a run that was
  // started by the final entry.
  task automatic set_nodes(input int v);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[4:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Loads a complete n x n triangle (diagonal included so that nothing the
  // merges touch is left unwritten) and starts the run with the final beat.
  // Shapes: random, all zero, narrow range with ties, sparse, near the top.
  // Half the entries are sent with row and column swapped, and for small n
  // some stray entries outside the active square are mixed in.
  task automatic load_matrix(input int n, input int shape);
    int total, k, d, r, c;
    total = n * (n + 1) / 2;
    k = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i; j < n; j++) begin
        k++;
        case (shape)
          1:       d = 0;
          2:       d = $urandom_range(1, 3);
          3:       d = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 65535) : 0;
          4:       d = $urandom_range(65530, 65535);
          default: d = $urandom_range(0, 65535);
        endcase
        if (n < MAX_NODES && $urandom_range(0, 9) == 0) begin
          r = $urandom_range(n, 15);
          c = $urandom_range(0, 15);
          offer_entry(r, c, $urandom, 1'b0);
        end
        if ($urandom_range(0, 1) == 1) begin
          r = j;
          c = i;
        end else begin
          r = i;
          c = j;
        end
        offer_entry(r, c, d, k == total);
      end
    end
  endtask

  initial begin
    int v, n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a node count of zero saturates to two, with the largest
    // distance as the only pair.
    set_nodes(0);
    offer_entry(0, 0, 65535, 1'b0);
    offer_entry(1, 1, 0, 1'b0);
    offer_entry(1, 0, 65535, 1'b1);
    // No nonzero pair at all: one beat with no_pair set.
    set_nodes(3);
    load_matrix(3, 1);
    // Distances of 1 to 3 give many ties for the first-pair tie rule.
    set_nodes(4);
    load_matrix(4, 2);
    // A single nonzero pair among zeros: no_pair appears mid-run.
    set_nodes(4);
    offer_entry(0, 0, 0, 1'b0);
    offer_entry(0, 1, 0, 1'b0);
    offer_entry(0, 2, 7, 1'b0);
    offer_entry(0, 3, 0, 1'b0);
    offer_entry(1, 1, 0, 1'b0);
    offer_entry(2, 1, 0, 1'b0);
    offer_entry(1, 3, 0, 1'b0);
    offer_entry(2, 2, 0, 1'b0);
    offer_entry(3, 2, 0, 1'b0);
    offer_entry(3, 3, 0, 1'b1);

    // Random runs. The first two hit the top of the range: 16, and 31
    // which saturates to 16. The long receiver hold-off lands on the third,
    // and the fourth keeps its node count so that its entries are offered
    // right away while the results of the third still back up in the block.
    for (int run = 0; beats_sent < 500; run++) begin
      if (run != 3) begin
        if (run == 0) v = 16;
        else if (run == 1) v = 31;
        else if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 31);
        else v = $urandom_range(2, 8);
        set_nodes(v);
        n = (v < 2) ? 2 : ((v > MAX_NODES) ? MAX_NODES : v);
      end
      steady <= ($urandom_range(0, 3) == 0);
      if (beats_sent > 420) calm <= 1'b1;
      if (run == 2) squeeze <= 1'b1;
      v = $urandom_range(0, 9);
      load_matrix(n, (v < 6) ? 0 : v - 5);
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/clc_pkg.sv
rtl/clc_dist_ram.sv
rtl/complete_linkage_clustering_top.sv
dv/clc_checker.sv
dv/complete_linkage_clustering_top_tb.sv
